### src/mseu_pkg.sv
// Package for the MIPS subset execute unit: action codes, sequencer states
// and the control struct passed to the shared arithmetic unit. No dependencies.
package mseu_pkg;

   typedef enum logic [3:0] {
      ACT_ADDI = 4'd0,
      ACT_SUBI = 4'd1,
      ACT_BEQ  = 4'd2,
      ACT_JUMP = 4'd3,
      ACT_LW   = 4'd4,
      ACT_SW   = 4'd5,
      ACT_ADD  = 4'd6,
      ACT_SUB  = 4'd7,
      ACT_MULT = 4'd8,
      ACT_DIV  = 4'd9,
      ACT_MFHI = 4'd10,
      ACT_MFLO = 4'd11
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_EXEC,
      ST_MEM,
      ST_ITER,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic        start;
      logic        is_div;
      logic [31:0] op_a;
      logic [31:0] op_b;
   } md_ctrl_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [31:0] hi;
      logic [31:0] lo;
   } md_stat_type;

   localparam int WORD_W = 32;

endpackage

### src/mseu_muldiv.sv
// Shared iterative multiply and divide unit, one bit per cycle.
// Depends on mseu_pkg for the control and status structs.
module mseu_muldiv (
   input  logic                 clock,
   input  logic                 reset,
   input  mseu_pkg::md_ctrl_type ctrl,
   output mseu_pkg::md_stat_type stat
);
   import mseu_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        div_ff, div_in;
   logic        neg_q_ff, neg_q_in;
   logic        neg_r_ff, neg_r_in;
   logic [31:0] b_ff, b_in;
   logic [63:0] acc_ff, acc_in;
   logic [32:0] diff;
   logic [32:0] sum;
   logic [31:0] q_fix;
   logic [31:0] r_fix;
   logic [63:0] p_fix;
   logic [31:0] mag_a;
   logic [31:0] mag_b;

   always_comb begin
      mag_a = ctrl.op_a[31] ? (~ctrl.op_a + 32'd1) : ctrl.op_a;
      mag_b = ctrl.op_b[31] ? (~ctrl.op_b + 32'd1) : ctrl.op_b;
      diff  = {acc_ff[63:31]} - {1'b0, b_ff};
      sum   = {1'b0, acc_ff[63:32]} + (acc_ff[0] ? {1'b0, b_ff} : 33'd0);
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      div_in   = div_ff;
      neg_q_in = neg_q_ff;
      neg_r_in = neg_r_ff;
      b_in     = b_ff;
      acc_in   = acc_ff;
      if (ctrl.start) begin
         busy_in  = 1'b1;
         cnt_in   = 5'd0;
         div_in   = ctrl.is_div;
         neg_q_in = ctrl.op_a[31] ^ ctrl.op_b[31];
         neg_r_in = ctrl.op_a[31];
         b_in     = mag_b;
         acc_in   = {32'd0, mag_a};
      end else if (busy_ff) begin
         if (div_ff) begin
            if (!diff[32]) begin
               acc_in = {diff[31:0], acc_ff[30:0], 1'b1};
            end else begin
               acc_in = {acc_ff[62:0], 1'b0};
            end
         end else begin
            acc_in = {sum, acc_ff[31:1]};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff   <= cnt_in;
      div_ff   <= div_in;
      neg_q_ff <= neg_q_in;
      neg_r_ff <= neg_r_in;
      b_ff     <= b_in;
      acc_ff   <= acc_in;
   end

   always_comb begin
      q_fix = neg_q_ff ? (~acc_ff[31:0] + 32'd1) : acc_ff[31:0];
      r_fix = neg_r_ff ? (~acc_ff[63:32] + 32'd1) : acc_ff[63:32];
      p_fix = neg_q_ff ? (~acc_ff + 64'd1) : acc_ff;
      stat.busy = busy_ff;
      stat.done = done_ff;
      stat.hi   = div_ff ? r_fix : p_fix[63:32];
      stat.lo   = div_ff ? q_fix : p_fix[31:0];
   end

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      stat.done |-> $past(busy_ff)) else $error("done without busy");
   a_not_both: assert property (@(posedge clock) disable iff (reset)
      !(busy_ff && done_ff)) else $error("busy and done together");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      ctrl.start |=> busy_ff) else $error("start did not raise busy");

endmodule

### src/mips_subset_execute_unit.sv
// Top level of the MIPS subset execute unit: register file, data memory,
// HI/LO and the sequencer. Depends on mseu_pkg and mseu_muldiv.
//
// Usage: one decoded instruction enters on the req_ channel (valid/ready);
// exactly one result item leaves on the rsp_ channel for each instruction.
// The block takes one instruction at a time. Registers are read in ST_READ
// and the item executes in ST_EXEC before rsp_valid rises in ST_DONE; lw/sw
// pass ST_MEM as well for the memory port. mult and div that write a register
// (div with a nonzero divisor) go through the shared bit-serial unit and wait
// in ST_ITER until it is done. req_ready is high only while the sequencer is
// idle, from the cycle after the result item is taken.
// After reset a clearing pass writes zero to every data memory word, one word
// per cycle; req_ready stays low meanwhile. Registers and HI/LO clear at once.
// While rsp_ready is low the result item holds in the output register and no
// new item is taken.
module mips_subset_execute_unit #(
   parameter int REG_COUNT  = 32,
   parameter int MEM_WORDS  = 1024,
   parameter int PROG_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [3:0]  req_action,
   input  logic [4:0]  req_dest_reg,
   input  logic [4:0]  req_src_a_reg,
   input  logic [4:0]  req_src_b_reg,
   input  logic signed [31:0] req_immediate,
   input  logic [7:0]  req_target_index,
   input  logic        req_target_found,
   input  logic        req_reg_write_en,
   input  logic        req_mem_read_en,
   input  logic        req_mem_write_en,
   input  logic        req_branch_en,
   input  logic        req_jump_en,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_branch_taken,
   output logic [7:0]  rsp_branch_target,
   output logic        rsp_reg_written,
   output logic [4:0]  rsp_written_reg,
   output logic signed [31:0] rsp_written_value,
   output logic        rsp_divide_by_zero
);
   import mseu_pkg::*;

   localparam int AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
   localparam int RW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

   state_type   state_ff, state_in;
   logic        clr_ff, clr_in;
   logic [AW:0] clr_cnt_ff, clr_cnt_in;

   logic [31:0] regs_ff [REG_COUNT];
   logic [31:0] mem [MEM_WORDS];
   logic [31:0] mem_rd_ff;
   logic [31:0] hi_ff, lo_ff;

   logic [3:0]  act_ff;
   logic [4:0]  rd_ff, ra_ff, rb_ff;
   logic [31:0] imm_ff;
   logic [7:0]  tgt_ff;
   logic        fnd_ff, rw_ff, mr_ff, mw_ff, br_ff, jp_ff;
   logic [31:0] vd_ff, va_ff, vb_ff;
   logic [AW-1:0] addr_ff;

   logic        o_tk_ff, o_wr_ff, o_dz_ff;
   logic [7:0]  o_tg_ff;
   logic [4:0]  o_rg_ff;
   logic [31:0] o_val_ff;

   logic        wr_en;
   logic [4:0]  wr_idx;
   logic [31:0] wr_val;
   logic        set_out;
   logic        o_tk, o_wr, o_dz;
   logic [31:0] o_val;
   logic        mem_we;
   logic [AW-1:0] mem_wa;
   logic [31:0] mem_wd;
   logic        hilo_we;
   logic [31:0] hilo_hi, hilo_lo;
   logic [31:0] a_q;
   logic [31:0] sum_addr;
   logic        tgt_ok;

   md_ctrl_type md_ctrl;
   md_stat_type md_stat;

   mseu_muldiv u_muldiv (
      .clock (clock),
      .reset (reset),
      .ctrl  (md_ctrl),
      .stat  (md_stat)
   );

   function automatic logic [31:0] rdreg(input logic [4:0] idx,
                                         input logic [31:0] v);
      rdreg = (32'(idx) < 32'(REG_COUNT)) ? v : 32'd0;
   endfunction

   always_comb begin
      a_q      = va_ff[31] ? (va_ff + 32'd3) : va_ff;
      a_q      = {{2{a_q[31]}}, a_q[31:2]};
      sum_addr = a_q + vb_ff;
      tgt_ok   = br_ff && jp_ff && fnd_ff && (32'(tgt_ff) < 32'(PROG_DEPTH));
   end

   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      clr_cnt_in = clr_cnt_ff;
      wr_en      = 1'b0;
      wr_idx     = rd_ff;
      wr_val     = 32'd0;
      set_out    = 1'b0;
      o_tk       = 1'b0;
      o_wr       = 1'b0;
      o_dz       = 1'b0;
      o_val      = 32'd0;
      mem_we     = 1'b0;
      mem_wa     = clr_cnt_ff[AW-1:0];
      mem_wd     = 32'd0;
      hilo_we    = 1'b0;
      hilo_hi    = md_stat.hi;
      hilo_lo    = md_stat.lo;
      md_ctrl    = '0;
      md_ctrl.op_a   = vd_ff;
      md_ctrl.op_b   = va_ff;
      md_ctrl.is_div = (act_ff == ACT_DIV);
      req_ready  = (state_ff == ST_IDLE) && !clr_ff;
      case (state_ff)
         ST_IDLE: begin
            if (clr_ff) begin
               mem_we     = 1'b1;
               clr_cnt_in = clr_cnt_ff + 1'b1;
               if (clr_cnt_ff == (AW+1)'(MEM_WORDS - 1)) begin
                  clr_in = 1'b0;
               end
            end else if (req_valid) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            case (act_ff)
               ACT_ADDI, ACT_SUBI, ACT_ADD, ACT_SUB, ACT_MFHI, ACT_MFLO: begin
                  case (act_ff)
                     ACT_ADDI: o_val = va_ff + imm_ff;
                     ACT_SUBI: o_val = va_ff - imm_ff;
                     ACT_ADD:  o_val = va_ff + vb_ff;
                     ACT_SUB:  o_val = va_ff - vb_ff;
                     ACT_MFHI: o_val = hi_ff;
                     default:  o_val = lo_ff;
                  endcase
                  o_wr    = rw_ff && (32'(rd_ff) < 32'(REG_COUNT));
                  set_out = 1'b1;
                  state_in = ST_DONE;
               end
               ACT_LW, ACT_SW: begin
                  state_in = ST_MEM;
               end
               ACT_BEQ: begin
                  o_tk    = tgt_ok && (vd_ff == va_ff);
                  set_out = 1'b1;
                  state_in = ST_DONE;
               end
               ACT_JUMP: begin
                  o_tk    = tgt_ok;
                  set_out = 1'b1;
                  state_in = ST_DONE;
               end
               ACT_MULT, ACT_DIV: begin
                  if (!rw_ff) begin
                     set_out  = 1'b1;
                     state_in = ST_DONE;
                  end else if (act_ff == ACT_DIV && va_ff == 32'd0) begin
                     o_dz     = 1'b1;
                     set_out  = 1'b1;
                     state_in = ST_DONE;
                  end else begin
                     md_ctrl.start = 1'b1;
                     state_in = ST_ITER;
                  end
               end
               default: begin
                  set_out  = 1'b1;
                  state_in = ST_DONE;
               end
            endcase
            wr_en  = o_wr;
            wr_val = o_val;
         end
         ST_MEM: begin
            if (act_ff == ACT_LW) begin
               o_wr  = mr_ff && rw_ff && (32'(rd_ff) < 32'(REG_COUNT));
               o_val = mem_rd_ff;
            end else begin
               mem_we = mw_ff;
               mem_wa = addr_ff;
               mem_wd = vd_ff;
            end
            wr_en    = o_wr;
            wr_val   = o_val;
            set_out  = 1'b1;
            state_in = ST_DONE;
         end
         ST_ITER: begin
            if (md_stat.done) begin
               hilo_we  = 1'b1;
               set_out  = 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         clr_ff     <= 1'b1;
         clr_cnt_ff <= '0;
         hi_ff      <= 32'd0;
         lo_ff      <= 32'd0;
         for (int i = 0; i < REG_COUNT; i++) begin
            regs_ff[i] <= 32'd0;
         end
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         clr_cnt_ff <= clr_cnt_in;
         if (hilo_we) begin
            hi_ff <= hilo_hi;
            lo_ff <= hilo_lo;
         end
         if (wr_en) begin
            regs_ff[wr_idx[RW-1:0]] <= wr_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      mem_rd_ff <= mem[sum_addr[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         act_ff <= req_action;
         rd_ff  <= req_dest_reg;
         ra_ff  <= req_src_a_reg;
         rb_ff  <= req_src_b_reg;
         imm_ff <= req_immediate;
         tgt_ff <= req_target_index;
         fnd_ff <= req_target_found;
         rw_ff  <= req_reg_write_en;
         mr_ff  <= req_mem_read_en;
         mw_ff  <= req_mem_write_en;
         br_ff  <= req_branch_en;
         jp_ff  <= req_jump_en;
      end
      if (state_ff == ST_READ) begin
         vd_ff <= rdreg(rd_ff, regs_ff[rd_ff[RW-1:0]]);
         va_ff <= rdreg(ra_ff, regs_ff[ra_ff[RW-1:0]]);
         vb_ff <= rdreg(rb_ff, regs_ff[rb_ff[RW-1:0]]);
      end
      if (state_ff == ST_EXEC) begin
         addr_ff <= sum_addr[AW-1:0];
      end
      if (set_out) begin
         o_tk_ff  <= o_tk;
         o_tg_ff  <= o_tk ? tgt_ff : 8'd0;
         o_wr_ff  <= o_wr;
         o_rg_ff  <= o_wr ? rd_ff : 5'd0;
         o_val_ff <= o_wr ? o_val : 32'd0;
         o_dz_ff  <= o_dz;
      end
   end

   assign rsp_valid          = (state_ff == ST_DONE);
   assign rsp_branch_taken   = o_tk_ff;
   assign rsp_branch_target  = o_tg_ff;
   assign rsp_reg_written    = o_wr_ff;
   assign rsp_written_reg    = o_rg_ff;
   assign rsp_written_value  = o_val_ff;
   assign rsp_divide_by_zero = o_dz_ff;

   a_no_accept_clearing: assert property (@(posedge clock) disable iff (reset)
      clr_ff |-> !req_ready) else $error("item accepted during clearing pass");
   a_accept_to_read: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_READ))
      else $error("accepted item did not start");
   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid) else $error("result item dropped");
   a_iter_unit_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ITER && !md_stat.done) |-> md_stat.busy)
      else $error("sequencer waits on idle unit");

endmodule

### tb/exec_checker.sv
// Checker for the MIPS subset execute unit: tracks register file, data memory
// and HI/LO, predicts each result item and compares it. Depends on mseu_pkg.
module exec_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [3:0]  req_action,
   input  logic [4:0]  req_dest_reg,
   input  logic [4:0]  req_src_a_reg,
   input  logic [4:0]  req_src_b_reg,
   input  logic signed [31:0] req_immediate,
   input  logic [7:0]  req_target_index,
   input  logic        req_target_found,
   input  logic        req_reg_write_en,
   input  logic        req_mem_read_en,
   input  logic        req_mem_write_en,
   input  logic        req_branch_en,
   input  logic        req_jump_en,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_branch_taken,
   input  logic [7:0]  rsp_branch_target,
   input  logic        rsp_reg_written,
   input  logic [4:0]  rsp_written_reg,
   input  logic signed [31:0] rsp_written_value,
   input  logic        rsp_divide_by_zero,
   output int          fail_count,
   output int          pending_count
);
   import mseu_pkg::*;

   localparam int MEM_DEPTH = 1024;

   typedef struct packed {
      logic        taken;
      logic [7:0]  target;
      logic        wrote;
      logic [4:0]  wreg;
      logic [31:0] wval;
      logic        dbz;
   } outcome_type;

   logic [31:0] regs [32];
   logic [31:0] mem [MEM_DEPTH];
   logic [31:0] hi_q, lo_q;
   outcome_type expected_q [$];

   function automatic logic [9:0] word_addr(logic [31:0] a, logic [31:0] b);
      longint s;
      s = longint'($signed(a)) / 4 + longint'($signed(b));
      s = s % MEM_DEPTH;
      if (s < 0) s += MEM_DEPTH;
      return s[9:0];
   endfunction

   task automatic execute_instruction();
      outcome_type o;
      logic [31:0] va, vb, vd;
      longint p, n, d;
      o = '0;
      va = regs[req_src_a_reg];
      vb = regs[req_src_b_reg];
      vd = regs[req_dest_reg];
      case (req_action)
         ACT_ADDI: begin o.wrote = req_reg_write_en; o.wval = va + req_immediate; end
         ACT_SUBI: begin o.wrote = req_reg_write_en; o.wval = va - req_immediate; end
         ACT_ADD:  begin o.wrote = req_reg_write_en; o.wval = va + vb; end
         ACT_SUB:  begin o.wrote = req_reg_write_en; o.wval = va - vb; end
         ACT_LW: begin
            if (req_mem_read_en && req_reg_write_en) begin
               o.wrote = 1'b1;
               o.wval = mem[word_addr(va, vb)];
            end
         end
         ACT_SW: if (req_mem_write_en) mem[word_addr(va, vb)] = vd;
         ACT_MULT: begin
            if (req_reg_write_en) begin
               p = longint'($signed(vd)) * longint'($signed(va));
               hi_q = p[63:32];
               lo_q = p[31:0];
            end
         end
         ACT_DIV: begin
            if (req_reg_write_en) begin
               n = longint'($signed(vd));
               d = longint'($signed(va));
               if (d == 0) o.dbz = 1'b1;
               else begin
                  p = n / d;
                  lo_q = p[31:0];
                  p = n % d;
                  hi_q = p[31:0];
               end
            end
         end
         ACT_MFHI: begin o.wrote = req_reg_write_en; o.wval = hi_q; end
         ACT_MFLO: begin o.wrote = req_reg_write_en; o.wval = lo_q; end
         ACT_BEQ: o.taken = req_branch_en && req_jump_en && req_target_found && vd == va;
         ACT_JUMP: o.taken = req_branch_en && req_jump_en && req_target_found;
         default: ;
      endcase
      if (o.taken) o.target = req_target_index;
      if (o.wrote) begin
         o.wreg = req_dest_reg;
         regs[req_dest_reg] = o.wval;
      end else o.wval = '0;
      expected_q.push_back(o);
   endtask

   always @(posedge clock) begin
      outcome_type e, a;
      if (reset) begin
         foreach (regs[i]) regs[i] = '0;
         foreach (mem[i]) mem[i] = '0;
         hi_q = '0;
         lo_q = '0;
         expected_q.delete();
         fail_count = 0;
      end else begin
         if (req_valid && req_ready) execute_instruction();
         if (rsp_valid && rsp_ready) begin
            a = {rsp_branch_taken, rsp_branch_target, rsp_reg_written, rsp_written_reg,
                 rsp_written_value, rsp_divide_by_zero};
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected result item %h", $time, a);
               fail_count++;
            end else begin
               e = expected_q.pop_front();
               if (e.taken != a.taken)
                  $display("%0t: branch_taken exp %0d got %0d", $time, e.taken, a.taken);
               if (e.target != a.target)
                  $display("%0t: branch_target exp %0d got %0d", $time, e.target, a.target);
               if (e.wrote != a.wrote)
                  $display("%0t: reg_written exp %0d got %0d", $time, e.wrote, a.wrote);
               if (e.wreg != a.wreg)
                  $display("%0t: written_reg exp %0d got %0d", $time, e.wreg, a.wreg);
               if (e.wval != a.wval)
                  $display("%0t: written_value exp %h got %h", $time, e.wval, a.wval);
               if (e.dbz != a.dbz)
                  $display("%0t: divide_by_zero exp %0d got %0d", $time, e.dbz, a.dbz);
               if (e != a) fail_count++;
            end
         end
      end
      pending_count = expected_q.size();
   end

endmodule

### tb/testbench.sv
// Top of the execute unit testbench: clock, reset, instruction stimulus and
// result back-pressure. Depends on mseu_pkg, mips_subset_execute_unit, exec_checker.
module testbench;
   import mseu_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [3:0]  req_action = '0;
   logic [4:0]  req_dest_reg = '0, req_src_a_reg = '0, req_src_b_reg = '0;
   logic signed [31:0] req_immediate = '0;
   logic [7:0]  req_target_index = '0;
   logic        req_target_found = 1'b0, req_reg_write_en = 1'b0;
   logic        req_mem_read_en = 1'b0, req_mem_write_en = 1'b0;
   logic        req_branch_en = 1'b0, req_jump_en = 1'b0;
   logic        rsp_valid, rsp_ready = 1'b0;
   logic        rsp_branch_taken, rsp_reg_written, rsp_divide_by_zero;
   logic [7:0]  rsp_branch_target;
   logic [4:0]  rsp_written_reg;
   logic signed [31:0] rsp_written_value;
   int          fail_count, pending_count;
   bit          long_hold = 1'b0;
   event        hold_go;

   always #2 clock = ~clock;

   mips_subset_execute_unit u_top (.*);
   exec_checker u_check (.*);

   function automatic int gap_length();
      if ($urandom_range(9) < 5) return 0;
      if ($urandom_range(9) < 8) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   function automatic logic [31:0] interesting_value();
      case ($urandom_range(7))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'hFFFF_FFFF;
         3: return 32'd0;
         4: return $urandom_range(20);
         5: return -$urandom_range(20);
         default: return $urandom;
      endcase
   endfunction

   task automatic send_instruction(action_type act, int rd, int ra, int rb,
                                   logic [31:0] imm, int tgt, logic [5:0] ctl);
      req_valid        <= 1'b1;
      req_action       <= act;
      req_dest_reg     <= 5'(rd);
      req_src_a_reg    <= 5'(ra);
      req_src_b_reg    <= 5'(rb);
      req_immediate    <= imm;
      req_target_index <= 8'(tgt);
      {req_target_found, req_reg_write_en, req_mem_read_en, req_mem_write_en,
       req_branch_en, req_jump_en} <= ctl;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic idle_sender(int n);
      if (n == 0) return;
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic send_random();
      action_type act;
      logic [5:0] ctl;
      int r;
      r = $urandom_range(99);
      ctl = (r < 80) ? 6'b111111 : 6'($urandom);
      act = action_type'($urandom_range(11));
      if (act == ACT_ADDI && $urandom_range(1))
         send_instruction(act, $urandom_range(31), $urandom_range(31), 0,
                          interesting_value(), $urandom_range(255), ctl);
      else
         send_instruction(act, $urandom_range(31), $urandom_range(31), $urandom_range(31),
                          $urandom, $urandom_range(255), ctl);
   endtask

   always @(posedge clock) begin
      if (long_hold) rsp_ready <= 1'b0;
      else if ($urandom_range(9) < 7) rsp_ready <= 1'b1;
      else rsp_ready <= ($urandom_range(9) == 0);
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < 32; i++) begin
         send_instruction(ACT_ADDI, i, 0, 0, interesting_value(), 0, 6'b010000);
         idle_sender(gap_length());
      end
      send_instruction(ACT_ADDI, 1, 0, 0, 32'h8000_0000, 0, 6'b010000);
      send_instruction(ACT_ADDI, 2, 0, 0, 32'hFFFF_FFFF, 0, 6'b010000);
      send_instruction(ACT_ADDI, 3, 0, 0, 32'h7FFF_FFFF, 0, 6'b010000);
      send_instruction(ACT_ADDI, 4, 0, 0, 32'd0, 0, 6'b010000);
      send_instruction(ACT_SUBI, 5, 3, 0, 32'h8000_0000, 0, 6'b010000);
      send_instruction(ACT_DIV, 1, 2, 0, 0, 0, 6'b010000);
      send_instruction(ACT_MFHI, 6, 0, 0, 0, 0, 6'b010000);
      send_instruction(ACT_MFLO, 7, 0, 0, 0, 0, 6'b010000);
      send_instruction(ACT_DIV, 3, 4, 0, 0, 0, 6'b010000);
      send_instruction(ACT_DIV, 3, 4, 0, 0, 0, 6'b000000);
      send_instruction(ACT_MULT, 1, 1, 0, 0, 0, 6'b010000);
      send_instruction(ACT_MFHI, 8, 0, 0, 0, 0, 6'b010000);
      send_instruction(ACT_SW, 3, 1, 2, 0, 0, 6'b000100);
      send_instruction(ACT_LW, 9, 1, 2, 0, 0, 6'b011000);
      send_instruction(ACT_LW, 9, 3, 3, 0, 0, 6'b001000);
      send_instruction(ACT_BEQ, 4, 4, 0, 0, 255, 6'b100011);
      send_instruction(ACT_BEQ, 4, 4, 0, 0, 7, 6'b100010);
      send_instruction(ACT_JUMP, 0, 0, 0, 0, 0, 6'b100011);
      send_instruction(ACT_JUMP, 0, 0, 0, 0, 9, 6'b000011);
      send_instruction(action_type'(4'd12), 31, 31, 31, '1, 255, 6'b111111);
      send_instruction(action_type'(4'd15), 0, 0, 0, 0, 0, 6'b111111);
      send_instruction(ACT_ADD, 10, 3, 3, 0, 0, 6'b010000);
      send_instruction(ACT_SUB, 11, 1, 3, 0, 0, 6'b010000);
      for (int i = 0; i < 395; i++) begin
         if (i == 100) -> hold_go;
         if (i == 200) begin
            req_valid <= 1'b0;
            do @(posedge clock); while (pending_count != 0);
         end
         send_random();
         idle_sender(gap_length());
      end
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (50) @(posedge clock);
      if (fail_count == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

   initial begin
      @(hold_go);
      long_hold <= 1'b1;
      repeat (300) @(posedge clock);
      long_hold <= 1'b0;
   end

   initial begin
      #2000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

### sim.f
src/mseu_pkg.sv
src/mseu_muldiv.sv
src/mips_subset_execute_unit.sv
tb/exec_checker.sv
tb/testbench.sv
